@@ rtl/midtones_transfer_stretch_macros.svh @@
// Assertion shorthands used by the top-level RTL file.
`ifndef MIDTONES_TRANSFER_STRETCH_MACROS_SVH
`define MIDTONES_TRANSFER_STRETCH_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mts_pkg.sv @@
package mts_pkg;

    // Width of every configuration register.
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SHADOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGHLIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCE   = 2'd2;

    // The balance is a fraction of this value.
    localparam logic [CFG_W:0] BAL_ONE = 17'h10000;

    localparam logic [CFG_W-1:0] BAL_RESET = 16'h8000;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_FULL,
        CLS_CALC
    } mts_cls_t;

    typedef struct packed {
        logic     valid;
        mts_cls_t cls;
    } mts_ctl_t;

endpackage

@@ rtl/mts_front.sv @@
module mts_front #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [PIXEL_BITS-1:0]         pixel,
    input  logic [mts_pkg::CFG_W-1:0]     shadow,
    input  logic [mts_pkg::CFG_W-1:0]     highlight,
    input  logic [mts_pkg::CFG_W-1:0]     balance,
    output mts_pkg::mts_ctl_t             ctl,
    output logic [PIXEL_BITS+15:0]        num,
    output logic [PIXEL_BITS+15:0]        den
);
    import mts_pkg::*;

    localparam int NUM_W  = PIXEL_BITS + CFG_W;
    localparam int CLIP_W = (PIXEL_BITS < CFG_W) ? PIXEL_BITS : CFG_W;

    logic [PIXEL_BITS-1:0] s_clip;
    logic [PIXEL_BITS-1:0] h_clip;

    // Stage A: classify against the clips, form a = v - s and d - a = h - v.
    mts_ctl_t              ctl_a_reg, ctl_a_next;
    logic [PIXEL_BITS-1:0] a_reg, a_next;
    logic [PIXEL_BITS-1:0] hv_reg, hv_next;
    logic [CFG_W-1:0]      bal_a_reg;

    // Stage B: the two products.
    mts_ctl_t              ctl_b_reg, ctl_b_next;
    logic [CFG_W:0]        inv_bal;
    logic [NUM_W-1:0]      num_b_reg, num_b_next;
    logic [NUM_W-1:0]      p2_b_reg, p2_b_next;
    logic [NUM_W:0]        num_wide;

    // Stage C: denominator.
    mts_ctl_t              ctl_c_reg;
    logic [NUM_W-1:0]      num_c_reg;
    logic [NUM_W-1:0]      den_c_reg, den_c_next;

    assign s_clip = PIXEL_BITS'(shadow[CLIP_W-1:0]);
    assign h_clip = PIXEL_BITS'(highlight[CLIP_W-1:0]);

    always_comb
    begin
        ctl_a_next.valid = in_valid;
        if (pixel <= s_clip)
        begin
            ctl_a_next.cls = CLS_ZERO;
        end
        else if (pixel >= h_clip)
        begin
            ctl_a_next.cls = CLS_FULL;
        end
        else
        begin
            ctl_a_next.cls = CLS_CALC;
        end
        a_next  = pixel - s_clip;
        hv_next = h_clip - pixel;
    end

    always_comb
    begin
        inv_bal    = BAL_ONE - {1'b0, bal_a_reg};
        num_wide   = inv_bal * a_reg;
        num_b_next = num_wide[NUM_W-1:0];
        p2_b_next  = bal_a_reg * hv_reg;
        ctl_b_next = ctl_a_reg;
        // With no balance the curve saturates for every pixel between the clips.
        if (ctl_a_reg.cls == CLS_CALC && bal_a_reg == '0)
        begin
            ctl_b_next.cls = CLS_FULL;
        end
    end

    assign den_c_next = num_b_reg + p2_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '{valid: 1'b0, cls: CLS_ZERO};
            ctl_b_reg <= '{valid: 1'b0, cls: CLS_ZERO};
            ctl_c_reg <= '{valid: 1'b0, cls: CLS_ZERO};
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_b_next;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            hv_reg    <= hv_next;
            bal_a_reg <= balance;
            num_b_reg <= num_b_next;
            p2_b_reg  <= p2_b_next;
            num_c_reg <= num_b_reg;
            den_c_reg <= den_c_next;
        end
    end

    assign ctl = ctl_c_reg;
    assign num = num_c_reg;
    assign den = den_c_reg;

endmodule

@@ rtl/mts_cell.sv @@
module mts_cell #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  mts_pkg::mts_ctl_t      ctl_in,
    input  logic [PIXEL_BITS+15:0] den_in,
    input  logic [PIXEL_BITS+15:0] num_in,
    input  logic [PIXEL_BITS+15:0] rem_in,
    input  logic [PIXEL_BITS-1:0]  quo_in,
    output mts_pkg::mts_ctl_t      ctl_out,
    output logic [PIXEL_BITS+15:0] den_out,
    output logic [PIXEL_BITS+15:0] num_out,
    output logic [PIXEL_BITS+15:0] rem_out,
    output logic [PIXEL_BITS-1:0]  quo_out
);
    import mts_pkg::*;

    localparam int NUM_W = PIXEL_BITS + CFG_W;

    mts_ctl_t              ctl_reg;
    logic [NUM_W-1:0]      den_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [PIXEL_BITS-1:0] quo_reg, quo_next;
    logic [NUM_W:0]        rem_dbl;
    logic [NUM_W:0]        rem_diff;
    logic                  take;

    // One restoring step: a remainder that enters below the divisor stays below it.
    always_comb
    begin
        rem_dbl  = {rem_in, 1'b0};
        rem_diff = rem_dbl - {1'b0, den_in};
        take     = (rem_dbl >= {1'b0, den_in});
        rem_next = take ? rem_diff[NUM_W-1:0] : rem_dbl[NUM_W-1:0];
        quo_next = {quo_in[PIXEL_BITS-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '{valid: 1'b0, cls: CLS_ZERO};
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_in;
            num_reg <= num_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign den_out = den_reg;
    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

@@ rtl/midtones_transfer_stretch.sv @@
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: pixel_in
// m_axis    out        m_axis_tvalid/tready       tdata: pixel_out
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One pixel is taken every cycle while the output is not stalled; a pixel passes
// through the three front stages, one divider cell per quotient bit and the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the stage valid bits and loads the register defaults.
// Configuration writes are always accepted.
`include "midtones_transfer_stretch_macros.svh"

module midtones_transfer_stretch #(
    parameter int PIXEL_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: pixel_in [PIXEL_BITS-1:0], zero padding above
    input  logic [((PIXEL_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: pixel_out [PIXEL_BITS-1:0], zero padding above
    output logic [((PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mts_pkg::CFG_W-1:0]           cfg_data
);
    import mts_pkg::*;

    localparam int DATA_W   = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int NUM_W    = PIXEL_BITS + CFG_W;
    localparam int OUT_KEEP = (PIXEL_BITS > CFG_W) ? CFG_W : PIXEL_BITS;
    localparam logic [PIXEL_BITS-1:0] OUT_MASK =
        {PIXEL_BITS{1'b1}} >> (PIXEL_BITS - OUT_KEEP);
    localparam logic [CFG_W-1:0] HIGH_RESET = CFG_W'({PIXEL_BITS{1'b1}});

    logic [CFG_W-1:0] shadow_reg, shadow_next;
    logic [CFG_W-1:0] highlight_reg, highlight_next;
    logic [CFG_W-1:0] balance_reg, balance_next;

    logic pipe_en;

    mts_ctl_t              ctl_s [0:PIXEL_BITS];
    logic [NUM_W-1:0]      den_s [0:PIXEL_BITS];
    logic [NUM_W-1:0]      num_s [0:PIXEL_BITS];
    logic [NUM_W-1:0]      rem_s [0:PIXEL_BITS];
    logic [PIXEL_BITS-1:0] quo_s [0:PIXEL_BITS];

    logic                  out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0] pixel_out_reg, pixel_out_next;
    logic [PIXEL_BITS-1:0] quo_fixed;
    logic [PIXEL_BITS-1:0] result;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        shadow_next    = shadow_reg;
        highlight_next = highlight_reg;
        balance_next   = balance_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SHADOW:    shadow_next    = cfg_data;
                REG_HIGHLIGHT: highlight_next = cfg_data;
                REG_BALANCE:   balance_next   = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg    <= '0;
            highlight_reg <= HIGH_RESET;
            balance_reg   <= BAL_RESET;
        end
        else
        begin
            shadow_reg    <= shadow_next;
            highlight_reg <= highlight_next;
            balance_reg   <= balance_next;
        end
    end

    // The whole pipeline moves as one whenever the output word can move on.
    assign pipe_en       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en;

    mts_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_axis_tvalid),
        .pixel     (s_axis_tdata[PIXEL_BITS-1:0]),
        .shadow    (shadow_reg),
        .highlight (highlight_reg),
        .balance   (balance_reg),
        .ctl       (ctl_s[0]),
        .num       (num_s[0]),
        .den       (den_s[0])
    );

    // The first cell starts from the numerator as its remainder.
    assign rem_s[0] = num_s[0];
    assign quo_s[0] = '0;

    for (genvar i = 0; i < PIXEL_BITS; i++)
    begin : g_cell
        mts_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (pipe_en),
            .ctl_in  (ctl_s[i]),
            .den_in  (den_s[i]),
            .num_in  (num_s[i]),
            .rem_in  (rem_s[i]),
            .quo_in  (quo_s[i]),
            .ctl_out (ctl_s[i+1]),
            .den_out (den_s[i+1]),
            .num_out (num_s[i+1]),
            .rem_out (rem_s[i+1]),
            .quo_out (quo_s[i+1])
        );
    end

    // The cells give floor(num * 2^N / den); scaling by 2^N - 1 instead takes
    // off one more unit exactly when the numerator exceeds the remainder.
    always_comb
    begin
        quo_fixed = quo_s[PIXEL_BITS]
                  - PIXEL_BITS'(num_s[PIXEL_BITS] > rem_s[PIXEL_BITS]);
        case (ctl_s[PIXEL_BITS].cls)
            CLS_ZERO: result = '0;
            CLS_FULL: result = '1;
            CLS_CALC: result = quo_fixed;
            default:  result = '0;
        endcase
        pixel_out_next = result & OUT_MASK;
        out_valid_next = pipe_en ? ctl_s[PIXEL_BITS].valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pixel_out_reg <= pixel_out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(pixel_out_reg);

    `MTS_ASSERT_NOW(a_rem_below_den, clk, rst_n,
        ctl_s[PIXEL_BITS].valid && ctl_s[PIXEL_BITS].cls == CLS_CALC,
        rem_s[PIXEL_BITS] < den_s[PIXEL_BITS],
        "divider remainder not below divisor")

    `MTS_ASSERT_NOW(a_no_underflow, clk, rst_n,
        ctl_s[PIXEL_BITS].valid && ctl_s[PIXEL_BITS].cls == CLS_CALC
            && num_s[PIXEL_BITS] > rem_s[PIXEL_BITS],
        quo_s[PIXEL_BITS] != '0,
        "quotient correction would wrap below zero")

    `MTS_ASSERT_NEXT(a_stall_freezes, clk, rst_n,
        !pipe_en,
        $stable(quo_s[PIXEL_BITS]) && $stable(ctl_s[PIXEL_BITS].valid),
        "divider chain moved while output was stalled")

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int PIX_W = 16;
    localparam logic [PIX_W-1:0] FULL = 16'hFFFF;
    // Index 3 has no register behind it; writes to it must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LATENCY = PIX_W + 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 125;

    class stretch_scoreboard;
        logic [CFG_W-1:0] shadow;
        logic [CFG_W-1:0] highlight;
        logic [CFG_W-1:0] balance;
        logic [PIX_W-1:0] stretched_q[$];
        int errors;

        function new();
            shadow = '0;
            highlight = FULL;
            balance = BAL_RESET;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SHADOW:    shadow = value;
                REG_HIGHLIGHT: highlight = value;
                REG_BALANCE:   balance = value;
                default:       ;
            endcase
        endfunction

        function logic [PIX_W-1:0] stretch(logic [PIX_W-1:0] v);
            longint unsigned a;
            longint unsigned d;
            longint unsigned m;
            longint unsigned num;
            longint unsigned den;
            longint unsigned q;
            if (v <= shadow)
                return '0;
            if (v >= highlight)
                return FULL;
            a = longint'(v) - longint'(shadow);
            d = longint'(highlight) - longint'(shadow);
            m = longint'(balance);
            num = (longint'(BAL_ONE) - m) * a;
            den = num + m * (d - a);
            // Both terms fit comfortably in 64 bits, so one exact division will do.
            q = (num * longint'(FULL)) / den;
            if (q > longint'(FULL))
                q = longint'(FULL);
            return q[PIX_W-1:0];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] v);
            stretched_q.push_back(stretch(v));
        endfunction

        function void check_pixel(logic [PIX_W-1:0] got);
            logic [PIX_W-1:0] want;
            if (stretched_q.size() == 0) begin
                $error("pixel_out: expected nothing, got %0d", got);
                errors++;
                return;
            end
            want = stretched_q.pop_front();
            if (got !== want) begin
                $error("pixel_out: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return stretched_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic steady = 1'b0;
    int quiet_cycles = 0;
    stretch_scoreboard sb = new();

    midtones_transfer_stretch #(.PIXEL_BITS(PIX_W)) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Signals read straight after the edge still hold their values from before it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata);
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Unless steady is set, the receiver stalls for a random number of cycles, possibly none, before taking each word.
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] v);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Called in the step of the last acceptance, so valid falls before another pixel goes in.
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] shadow, input logic [CFG_W-1:0] highlight,
                                input logic [CFG_W-1:0] balance, input bit poke_unused);
        write_reg(REG_SHADOW, shadow);
        write_reg(REG_HIGHLIGHT, highlight);
        write_reg(REG_BALANCE, balance);
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed(input logic [CFG_W-1:0] shadow, input logic [CFG_W-1:0] highlight,
                                input logic [CFG_W-1:0] balance, input bit poke_unused,
                                input logic [PIX_W-1:0] pixels[$]);
        program_regs(shadow, highlight, balance, poke_unused);
        foreach (pixels[i])
            send_pixel(pixels[i]);
        drain_pixels();
    endtask

    initial
    begin
        logic [CFG_W-1:0] shadow;
        logic [CFG_W-1:0] highlight;
        logic [CFG_W-1:0] balance;
        logic [PIX_W-1:0] v;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults first: a plain linear map over the full range.
        steady = 1'b1;
        send_pixel(16'h0000);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        send_pixel(16'hFFFE);
        send_pixel(16'hFFFF);
        drain_pixels();
        steady = 1'b0;

        // Extremes of the clips and of the balance, then the inverted and equal clips.
        run_directed(16'h8000, 16'hFFFF, 16'd7, 1'b0,
                     '{16'h8000, 16'h8001, 16'hC000, 16'hFFFE});
        run_directed(16'h0000, 16'h8000, 16'd65529, 1'b0,
                     '{16'h0001, 16'h4000, 16'h7FFF, 16'h8000});
        // A zero balance sends everything between the clips to full scale.
        run_directed(16'd100, 16'd200, 16'd0, 1'b0, '{16'd101, 16'd150, 16'd199});
        run_directed(16'h8000, 16'h8000, 16'hFFFF, 1'b1, '{16'h7FFF, 16'h8000, 16'h8001});
        run_directed(16'h9000, 16'h8000, BAL_RESET, 1'b0, '{16'h8800, 16'h9001});

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       shadow = '0;
                1:       shadow = 16'h8000;
                2:       shadow = CFG_W'($urandom);
                default: shadow = CFG_W'($urandom_range(0, 32768));
            endcase
            case ($urandom_range(0, 5))
                0:       highlight = 16'h8000;
                1:       highlight = FULL;
                2:       highlight = CFG_W'($urandom);
                default: highlight = CFG_W'($urandom_range(32768, 65535));
            endcase
            case ($urandom_range(0, 7))
                0:       balance = 16'd7;
                1:       balance = 16'd65529;
                2:       balance = BAL_RESET;
                3:       balance = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 6))
                                                            : CFG_W'($urandom_range(65530, 65535));
                default: balance = CFG_W'($urandom_range(7, 65529));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            program_regs(shadow, highlight, balance, $urandom_range(0, 3) == 0);

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case ($urandom_range(0, 9))
                    6:       v = shadow;
                    7:       v = highlight;
                    8:       v = ($urandom_range(0, 1) != 0) ? shadow + 1'b1 : highlight - 1'b1;
                    9:       v = PIX_W'($urandom);
                    default: v = (highlight > shadow + 1)
                                 ? PIX_W'($urandom_range(shadow + 1, highlight - 1))
                                 : PIX_W'($urandom);
                endcase
                send_pixel(v);
                // Now and then let the pipeline run dry in the middle of a phase.
                if ($urandom_range(0, 199) == 0 && i != PHASE_ITEMS - 1) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge clk); while (sb.pending() != 0);
                end
            end
            drain_pixels();
        end

        repeat (LATENCY + 4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
